[hw/rtl/gumbel_max_argmax_sampler_defines.svh]
// Assertion macros for the Gumbel-max sampler.
`ifndef GUMBEL_MAX_ARGMAX_SAMPLER_DEFINES_SVH
`define GUMBEL_MAX_ARGMAX_SAMPLER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define GMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define GMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/gms_pkg.sv]
// Package: widths, constants, word layouts and float helpers for the Gumbel-max sampler.
package gms_pkg;
    localparam int TableAddrBitsDef = 16;
    localparam int IndexBitsDef     = 18;
    localparam int AddrFieldBits    = 16;
    localparam int SeedBits         = 16;
    localparam logic [31:0] NegInfBits = 32'hFF80_0000;
    localparam logic [31:0] QNanBits   = 32'h7FC0_0000;
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_SCORE = 1'b1;

    // input word: mode, table_addr, value_bits, row_seed, last_in_row
    typedef struct packed {
        logic                     mode;
        logic [AddrFieldBits-1:0] table_addr;
        logic [31:0]              value_bits;
        logic [SeedBits-1:0]      row_seed;
        logic                     last_in_row;
    } in_word_t;

    // result word: best_index, best_score_bits
    typedef struct packed {
        logic [IndexBitsDef-1:0] best_index;
        logic [31:0]             best_score_bits;
    } out_word_t;

    function automatic logic is_nan(input logic [31:0] f);
        is_nan = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    // a > b in IEEE order, false on NaN, +0 == -0.
    function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
        logic az;
        logic bz;
        az = (a[30:0] == 31'd0);
        bz = (b[30:0] == 31'd0);
        if (is_nan(a) || is_nan(b))       fp_gt = 1'b0;
        else if (az && bz)                fp_gt = 1'b0;
        else if (!a[31] && b[31])         fp_gt = 1'b1;
        else if (a[31] && !b[31])         fp_gt = 1'b0;
        else if (!a[31])                  fp_gt = a[30:0] > b[30:0];
        else                              fp_gt = a[30:0] < b[30:0];
    endfunction
endpackage

[hw/rtl/gms_stream_if.sv]
// Valid/ready channel interface carrying a generic payload.
interface gms_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/gms_fp_add.sv]
// Two-stage IEEE single adder, round to nearest even.
module gms_fp_add
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] sum
);
    // stage 1: order operands, align
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [23:0] mb;
    logic [23:0] ms;
    logic [8:0]  sh;
    logic [26:0] msal;
    logic [49:0] wide;
    logic        special;
    logic [31:0] special_val;

    logic [26:0] mb_reg;
    logic [26:0] ms_reg;
    logic [7:0]  e_reg;
    logic        s_reg;
    logic        sub_reg;
    logic        special_reg;
    logic [31:0] special_val_reg;
    logic        vld_reg;

    always_comb
    begin
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        eb = big[30:23];
        es = sml[30:23];
        mb = {(eb != 8'd0), big[22:0]};
        ms = {(es != 8'd0), sml[22:0]};
        sh = {1'b0, (eb == 8'd0) ? 8'd1 : eb} - {1'b0, (es == 8'd0) ? 8'd1 : es};
        wide = {ms, 26'd0} >> ((sh > 9'd26) ? 9'd26 : sh);
        msal = {wide[49:24], (wide[23:0] != 24'd0)};
        special = 1'b0;
        special_val = 32'd0;
        if (gms_pkg::is_nan(a) || gms_pkg::is_nan(b))
        begin
            special = 1'b1;
            special_val = gms_pkg::QNanBits;
        end
        else if (eb == 8'hFF)
        begin
            special = 1'b1;
            special_val = (sml[30:23] == 8'hFF && sml[31] != big[31]) ?
                gms_pkg::QNanBits : big;
        end
        else if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
        begin
            special = 1'b1;
            special_val = {a[31] & b[31], 31'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mb_reg          <= {mb, 3'd0};
            ms_reg          <= msal;
            e_reg           <= (eb == 8'd0) ? 8'd1 : eb;
            s_reg           <= big[31];
            sub_reg         <= a[31] ^ b[31];
            special_reg     <= special;
            special_val_reg <= special_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= 1'b1;
    end

    // stage 2: add, normalize, round
    logic [27:0] raw;
    logic [4:0]  lz;
    logic [27:0] nrm;
    logic [9:0]  en_exp;
    logic [23:0] mant;
    logic [24:0] rnd;
    logic        lsb;
    logic        grd;
    logic        stk;
    logic [9:0]  fexp;
    logic [31:0] res;

    always_comb
    begin
        raw = sub_reg ? ({1'b0, mb_reg} - {1'b0, ms_reg}) : ({1'b0, mb_reg} + {1'b0, ms_reg});
        // priority leading-one search
        lz = 5'd28;
        for (int i = 0; i <= 27; i++)
        begin
            if (raw[i])
                lz = 5'(27 - i);
        end
        nrm = 28'd0;
        en_exp = 10'd0;
        if (raw[27])
        begin
            nrm = {1'b0, raw[27:2], raw[1] | raw[0]};
            en_exp = {2'b0, e_reg} + 10'd1;
        end
        else if ({5'd0, lz} - 10'd1 < {2'b0, e_reg} - 10'd1 || lz == 5'd1)
        begin
            nrm = raw << (lz - 5'd1);
            en_exp = {2'b0, e_reg} - {5'd0, lz} + 10'd1;
        end
        else
        begin
            nrm = raw << (e_reg - 8'd1);
            en_exp = 10'd0;
        end
        mant = nrm[26:3];
        lsb = nrm[3];
        grd = nrm[2];
        stk = nrm[1] | nrm[0];
        rnd = {1'b0, mant} + {24'd0, grd & (stk | lsb)};
        fexp = en_exp;
        if (rnd[24])
        begin
            fexp = en_exp + 10'd1;
            rnd = rnd >> 1;
        end
        else if (en_exp == 10'd0 && rnd[23])
            fexp = 10'd1;
        if (raw == 28'd0)
            res = 32'd0;
        else if (fexp >= 10'd255)
            res = {s_reg, 8'hFF, 23'd0};
        else
            res = {s_reg, fexp[7:0], rnd[22:0]};
        sum = special_reg ? special_val_reg : res;
    end

    `include "gumbel_max_argmax_sampler_defines.svh"
    `GMS_ASSERT_IMP(a_nan_out, special_reg && gms_pkg::is_nan(special_val_reg), gms_pkg::is_nan(sum), "nan lost")
    `GMS_ASSERT_IMP(a_zero_sum, vld_reg && !special_reg && raw == 28'd0, sum == 32'd0, "zero sign")
    `GMS_ASSERT_NEXT(a_vld, en, vld_reg, "stage invalid")
endmodule

[hw/rtl/gumbel_max_argmax_sampler.sv]
// Top level: streaming Gumbel-max argmax sampler over a float32 logit row.
// One word per cycle in, back to back, unless stalled. A score word reads the
// noise memory (one synchronous read port) at seed+position, adds the noise
// in a two-stage float adder and compares against the running best; a row's
// result is queued at the compare stage after its last score word passes the
// memory read and the adder; sustained rate one word per cycle while out_ch
// drains, set by the single memory read port and the adder pipeline. Table
// writes share the memory's write port and pass through the pipe as bubbles.
// The running best lives in registers at the compare stage, so rows follow
// each other with no gap. Results wait in a four-entry output queue that
// reserves a slot for every row end still in the pipe; input stalls only
// when that queue could overflow. Entries never written read undefined.
module gumbel_max_argmax_sampler #(
    parameter int TABLE_ADDR_BITS = gms_pkg::TableAddrBitsDef
)(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    gms_stream_if.sink   in_ch,
    gms_stream_if.source out_ch
);
    localparam int INDEX_BITS = gms_pkg::IndexBitsDef;
    localparam int Depth = 1 << TABLE_ADDR_BITS;
    localparam int QDepth = 4;
    localparam logic [INDEX_BITS-1:0] IndexMax = {INDEX_BITS{1'b1}};

    // in_ch.data: mode, table_addr, value_bits, row_seed, last_in_row
    // out_ch.data: best_index, best_score_bits
    logic accept;
    logic noise_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            noise_enable_reg <= 1'b1;
        else if (cfg_we)
            noise_enable_reg <= cfg_wdata;
    end

    // position counter (front end, counts score words)
    logic [INDEX_BITS-1:0] pos_reg;
    logic [TABLE_ADDR_BITS-1:0] rd_addr;
    logic [TABLE_ADDR_BITS-1:0] wr_addr;
    logic [31:0] noise_mem [Depth];
    logic [31:0] noise_rd_reg;
    logic is_score;

    assign is_score = in_ch.data.mode == gms_pkg::MODE_SCORE;
    assign accept = in_ch.valid && in_ch.ready;

    logic [31:0] seed_ext;
    logic [31:0] pos_ext;
    logic [31:0] addr_ext;
    always_comb
    begin
        seed_ext = 32'(in_ch.data.row_seed);
        pos_ext  = 32'(pos_reg);
        addr_ext = 32'(in_ch.data.table_addr);
        rd_addr  = TABLE_ADDR_BITS'(seed_ext + pos_ext);
        wr_addr  = TABLE_ADDR_BITS'(addr_ext);
    end

    always_ff @(posedge clk)
    begin
        if (accept && !is_score)
            noise_mem[wr_addr] <= in_ch.data.value_bits;
        noise_rd_reg <= noise_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (accept && is_score)
        begin
            if (in_ch.data.last_in_row)
                pos_reg <= '0;
            else if (pos_reg != IndexMax)
                pos_reg <= pos_reg + 1'b1;
        end
    end

    // stage 1: memory read in flight
    logic                  v1_reg;
    logic                  last1_reg;
    logic [31:0]           logit1_reg;
    logic [INDEX_BITS-1:0] idx1_reg;
    logic                  ne1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= accept && is_score;
    end
    always_ff @(posedge clk)
    begin
        last1_reg  <= in_ch.data.last_in_row;
        logit1_reg <= in_ch.data.value_bits;
        idx1_reg   <= pos_reg;
        ne1_reg    <= noise_enable_reg;
    end

    // stage 2/3: float add
    logic [31:0] noise_sel;
    logic [31:0] sum;
    assign noise_sel = ne1_reg ? noise_rd_reg : 32'h8000_0000;

    gms_fp_add u_add (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (1'b1),
        .a     (logit1_reg),
        .b     (noise_sel),
        .sum   (sum)
    );

    logic                  v2_reg;
    logic                  last2_reg;
    logic [INDEX_BITS-1:0] idx2_reg;
    logic [31:0]           logit2_reg;
    logic                  ne2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        last2_reg  <= last1_reg;
        idx2_reg   <= idx1_reg;
        logit2_reg <= logit1_reg;
        ne2_reg    <= ne1_reg;
    end

    // stage 3: compare and update running best (greedy keeps raw bits)
    logic [31:0]           score;
    logic [31:0]           best_s_reg;
    logic [INDEX_BITS-1:0] best_i_reg;
    logic                  win;
    logic [31:0]           new_s;
    logic [INDEX_BITS-1:0] new_i;
    assign score = ne2_reg ? sum : logit2_reg;
    assign win   = gms_pkg::fp_gt(score, best_s_reg);
    assign new_s = win ? score : best_s_reg;
    assign new_i = win ? idx2_reg : best_i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_s_reg <= gms_pkg::NegInfBits;
            best_i_reg <= '0;
        end
        else if (v2_reg)
        begin
            best_s_reg <= last2_reg ? gms_pkg::NegInfBits : new_s;
            best_i_reg <= last2_reg ? '0 : new_i;
        end
    end

    // output queue, four entries; row ends still in the pipe are reserved
    logic [INDEX_BITS-1:0] qi_reg [QDepth];
    logic [31:0]           qs_reg [QDepth];
    logic [2:0]            cnt_reg;
    logic [1:0]            rp_reg;
    logic [1:0]            wp_reg;
    logic                  push;
    logic                  pop;
    logic [2:0]            inflight;

    assign push = v2_reg && last2_reg;
    assign pop  = out_ch.valid && out_ch.ready;
    assign inflight = cnt_reg + 3'(v1_reg && last1_reg) + 3'(v2_reg && last2_reg);
    assign in_ch.ready = inflight < 3'd4 || (inflight == 3'd4 && pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rp_reg  <= '0;
            wp_reg  <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qi_reg[wp_reg] <= new_i;
            qs_reg[wp_reg] <= new_s;
        end
    end

    assign out_ch.valid = cnt_reg != 3'd0;
    assign out_ch.data.best_index = qi_reg[rp_reg];
    assign out_ch.data.best_score_bits = qs_reg[rp_reg];

    `include "gumbel_max_argmax_sampler_defines.svh"
    `GMS_ASSERT_IMP(a_q_bound, 1'b1, cnt_reg <= 3'd4, "queue overflow")
    `GMS_ASSERT_IMP(a_no_ovf, push && !pop, cnt_reg < 3'd4, "push into full queue")
    `GMS_ASSERT_NEXT(a_row_clear, v2_reg && last2_reg, best_s_reg == gms_pkg::NegInfBits, "row not reset")
endmodule

[dv/gumbel_max_argmax_sampler_tb.sv]
// Testbench for the Gumbel-max argmax sampler: random and directed rows checked against a predictor.
module gumbel_max_argmax_sampler_tb;
    // Payload layouts of the two channels, field order as in the block's item.
    typedef gms_pkg::in_word_t  sample_in_t;
    typedef gms_pkg::out_word_t sample_out_t;

    localparam int IDX_W = gms_pkg::IndexBitsDef;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;
    localparam int STALL_LIMIT = 10000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_WORDS = 115;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    gms_stream_if #(.payload_t(sample_in_t))  in_ch ();
    gms_stream_if #(.payload_t(sample_out_t)) out_ch ();

    gumbel_max_argmax_sampler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Words waiting to be sent, and row winners waiting to come out.
    sample_in_t  send_q[$];
    sample_out_t winner_q[$];

    int  idle_pct;
    int  stall_pct;
    int  err_cnt = 0;
    bit  noise_on;        // predictor copy of noise_enable
    bit  gen_noise_on;    // what the generator plans for
    bit  gen_written[int];

    // Predictor state.
    logic [31:0]      noise_mem [int];
    logic [IDX_W-1:0] row_pos = '0;
    logic [31:0]      row_best_bits = gms_pkg::NegInfBits;
    logic [IDX_W-1:0] best_pos = '0;

    // ---------------------------------------------------------------
    // Float helpers: single-precision add with round to nearest even,
    // and an IEEE greater-than built on an ordered integer key.
    // ---------------------------------------------------------------
    function automatic bit f32_is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 0);
    endfunction

    function automatic logic [31:0] f32_order_key(input logic [31:0] f);
        logic [31:0] g;
        g = (f[30:0] == 0) ? 32'd0 : f;   // -0 and +0 collapse
        return g[31] ? ~g : (g | 32'h8000_0000);
    endfunction

    function automatic bit f32_beats(input logic [31:0] a, input logic [31:0] b);
        if (f32_is_nan(a) || f32_is_nan(b))
            return 1'b0;
        return f32_order_key(a) > f32_order_key(b);
    endfunction

    function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [27:0] mx;
        logic [27:0] my;
        logic [27:0] m;
        logic [24:0] r;
        int          ex;
        int          ey;
        int          e;
        int          d;
        logic        sticky;
        if (f32_is_nan(a) || f32_is_nan(b))
            return gms_pkg::QNanBits;
        if (a[30:0] == 31'h7F80_0000)
        begin
            if (b[30:0] == 31'h7F80_0000 && a[31] != b[31])
                return gms_pkg::QNanBits;
            return a;
        end
        if (b[30:0] == 31'h7F80_0000)
            return b;
        if (a[30:0] == 0 && b[30:0] == 0)
            return {a[31] & b[31], 31'd0};
        x = a;
        y = b;
        if (b[30:0] > a[30:0])
        begin
            x = b;
            y = a;
        end
        ex = (x[30:23] == 0) ? 1 : x[30:23];
        ey = (y[30:23] == 0) ? 1 : y[30:23];
        mx = {1'b0, x[30:23] != 0, x[22:0], 3'b000};
        my = {1'b0, y[30:23] != 0, y[22:0], 3'b000};
        d = ex - ey;
        if (d > 26)
            my = {27'd0, my != 0};
        else if (d > 0)
        begin
            sticky = (my & ((28'd1 << d) - 28'd1)) != 0;
            my = (my >> d) | {27'd0, sticky};
        end
        m = (x[31] == y[31]) ? mx + my : mx - my;
        if (m == 0)
            return 32'd0;
        e = ex;
        if (m[27])
        begin
            m = (m >> 1) | {27'd0, m[0]};
            e = e + 1;
        end
        else
        begin
            while (!m[26] && e > 1)
            begin
                m = m << 1;
                e = e - 1;
            end
        end
        r = {1'b0, m[26:3]} + (m[2] && (m[1] || m[0] || m[3]));
        if (r[24])
        begin
            r = r >> 1;
            e = e + 1;
        end
        if (e >= 255)
            return {x[31], 8'hFF, 23'd0};
        return {x[31], r[23] ? e[7:0] : 8'd0, r[22:0]};
    endfunction

    // ---------------------------------------------------------------
    // Predictor: folds one accepted word in: a table write into the table copy, a score word into the row best.
    // ---------------------------------------------------------------
    task automatic score_word(input sample_in_t w);
        logic [31:0] score;
        logic [15:0] rd_addr;
        sample_out_t res;
        if (w.mode == gms_pkg::MODE_WRITE)
        begin
            noise_mem[w.table_addr] = w.value_bits;
            return;
        end
        rd_addr = w.row_seed + row_pos[15:0];
        score = noise_on ? f32_add(w.value_bits, noise_mem[rd_addr]) : w.value_bits;
        if (f32_beats(score, row_best_bits))
        begin
            row_best_bits = score;
            best_pos      = row_pos;
        end
        if (row_pos != IDX_MAX)
            row_pos = row_pos + 1'b1;
        if (w.last_in_row)
        begin
            res.best_index      = best_pos;
            res.best_score_bits = row_best_bits;
            winner_q.push_back(res);
            row_pos       = '0;
            row_best_bits = gms_pkg::NegInfBits;
            best_pos      = '0;
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus builders.
    // ---------------------------------------------------------------
    function automatic logic [31:0] rand_f32();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(11))
            0: ;                                                    // any pattern
            1: f = {f[31], 8'hFF, f[22:1], 1'b1};                   // NaN
            2: f = {f[31], 8'hFF, 23'd0};                           // infinity
            3: f = {f[31], 31'd0};                                  // zero
            4: f = {f[31], 8'd0, f[22:0]};                          // subnormal
            5: f = {f[31], 8'hFE, f[22:0]};                         // near overflow
            6: f = {f[31], 8'd1, f[22:0]};                          // near underflow
            default: f = {f[31], 8'($urandom_range(120, 132)), f[22:0]};
        endcase
        return f;
    endfunction

    task automatic push_word(input logic m, input logic [15:0] addr, input logic [31:0] v,
                             input logic [15:0] seed, input logic last);
        sample_in_t w;
        w.mode        = m;
        w.table_addr  = addr;
        w.value_bits  = v;
        w.row_seed    = seed;
        w.last_in_row = last;
        if (m == gms_pkg::MODE_WRITE)
            gen_written[addr] = 1'b1;
        send_q.push_back(w);
    endtask

    // Table write with junk in the unused fields.
    task automatic push_noise(input logic [15:0] addr, input logic [31:0] v);
        push_word(gms_pkg::MODE_WRITE, addr, v, 16'($urandom), 1'($urandom));
    endtask

    // One row of given logits; with noise planned, first fills any unwritten table entries the row will read.
    task automatic push_row(input logic [31:0] logits[$], input logic [15:0] seed);
        logic [15:0] a;
        for (int p = 0; p < logits.size(); p++)
        begin
            a = seed + p[15:0];
            if (gen_noise_on && !gen_written.exists(a))
                push_noise(a, rand_f32());
        end
        foreach (logits[p])
        begin
            // stray table writes inside the row
            if ($urandom_range(9) == 0)
                push_noise(16'($urandom), rand_f32());
            push_word(gms_pkg::MODE_SCORE, 16'($urandom), logits[p], seed,
                      p == logits.size() - 1);
        end
    endtask

    task automatic push_random_rows(input int n_words);
        logic [31:0] row[$];
        int          len;
        int          cnt;
        cnt = 0;
        while (cnt < n_words)
        begin
            row = {};
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                // sprinkle exact repeats to hit ties
                if (i > 0 && $urandom_range(5) == 0)
                    row.push_back(row[$urandom_range(i - 1)]);
                else
                    row.push_back(rand_f32());
            end
            push_row(row, 16'($urandom));
            cnt += len;
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: pops the send queue, holds a word until it is taken.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (send_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= send_q.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: predicts on accepted input, checks accepted results.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_out_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                score_word(in_ch.data);
            if (out_ch.valid && out_ch.ready)
            begin
                if (winner_q.size() == 0)
                begin
                    $error("unexpected result: index %0d score %h",
                           out_ch.data.best_index, out_ch.data.best_score_bits);
                    err_cnt++;
                end
                else
                begin
                    want = winner_q.pop_front();
                    if (out_ch.data.best_index !== want.best_index)
                    begin
                        $error("best_index: expected %0d, got %0d",
                               want.best_index, out_ch.data.best_index);
                        err_cnt++;
                    end
                    if (out_ch.data.best_score_bits !== want.best_score_bits)
                    begin
                        $error("best_score_bits: expected %h, got %h",
                               want.best_score_bits, out_ch.data.best_score_bits);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no handshake while work is outstanding.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (send_q.size() == 0 && winner_q.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("gumbel_max_argmax_sampler_tb: errors");
            $finish;
        end
    end

    // The sequence holds back until every queued word is in and every winner is out.
    task automatic drain();
        while (send_q.size() != 0 || in_ch.valid || winner_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_noise(input bit en);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        noise_on     = en;
        gen_noise_on = en;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Sequence of phases.
    // ---------------------------------------------------------------
    initial
    begin
        logic [31:0] row[$];
        int          idle_plan[6];
        int          stall_plan[6];
        bit          noise_plan[6];
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        noise_on     = 1'b1;   // register resets to noise enabled
        gen_noise_on = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, noise on from reset: table extremes and address wrap.
        push_noise(16'hFFFF, 32'h3F80_0000);          // +1.0
        push_noise(16'h0000, 32'hBF80_0000);          // -1.0
        push_noise(16'h0001, 32'h7F80_0000);          // +inf
        push_noise(16'h0002, 32'h7F7F_FFFF);          // max normal
        row = {32'h4000_0000, 32'h4000_0000, 32'hFF80_0000, 32'h7F7F_FFFF};
        push_row(row, 16'hFFFF);                      // seed wraps past end of table
        row = {32'h7FC0_0001, 32'hFFFF_FFFF};         // NaN in, no winner
        push_row(row, 16'h0000);
        row = {32'h3F80_0000};                        // -1 + 1 = +0 single element
        push_row(row, 16'h0000);
        drain();

        // Directed greedy: ties, signed zeros, NaN, infinities, subnormals.
        set_noise(1'b0);
        row = {32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001};
        push_row(row, 16'h1234);
        row = {32'h7FC0_0000, 32'hFF80_0000, 32'h7FFF_FFFF};
        push_row(row, 16'hABCD);
        row = {32'hFF7F_FFFF, 32'h7F80_0000, 32'h7F80_0000};
        push_row(row, 16'h0000);
        drain();

        // Random phases with idling on each side.
        idle_plan  = '{0, 67, 0, 32, 67, 0};
        stall_plan = '{0, 0, 67, 32, 0, 67};
        noise_plan = '{1, 0, 1, 1, 1, 0};
        foreach (idle_plan[ph])
        begin
            set_noise(noise_plan[ph]);
            idle_pct  = idle_plan[ph];
            stall_pct = stall_plan[ph];
            push_random_rows(PHASE_WORDS);
            drain();
        end

        if (err_cnt == 0)
            $display("gumbel_max_argmax_sampler_tb: clean");
        else
            $display("gumbel_max_argmax_sampler_tb: errors");
        $finish;
    end
endmodule
